/* rtl/tlnef_pkg.sv */
// tlnef_pkg: shared types and constants of the cooked text line filter
// no dependencies; used by every module under rtl
package tlnef_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 1;

    // register indexes on the write port
    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_LINES   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_NONBLANK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_BLANK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_ENDS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_TABS      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_NONPRINT  = 3'd5;

    // character codes
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_I      = 8'h49;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_CTRL_END = 8'h20;
    localparam logic [7:0] CTRL_OFFSET = 8'h40;

    localparam int BODY_MAX = 4;
    localparam int BODY_LEN_W = 3;

    typedef struct packed {
        logic number_lines;
        logic number_nonblank_only;
        logic squeeze_blank;
        logic show_ends;
        logic show_tabs;
        logic show_nonprint;
    } tlnef_cfg_t;

    // rewritten body of one item, without the line number prefix
    typedef struct packed {
        logic [BODY_MAX-1:0][7:0] bytes;
        logic [BODY_LEN_W-1:0]    len;
    } tlnef_body_t;

endpackage

/* rtl/text_line_number_and_escape_filter_top.sv */
// text_line_number_and_escape_filter_top: cooked text output filter, top level
// depends on tlnef_pkg, tlnef_cfg, tlnef_front, tlnef_ser
//
//  channel  | signals                                   | moves
//  ---------+-------------------------------------------+---------------------------
//  input    | in_valid, in_ready, in_byte, new_file     | one text byte per item
//  output   | out_valid, out_ready, out_byte, last      | one rewritten byte per item
//  config   | wr_en, wr_index, wr_data                  | one option bit per write
//
// an input item is decoded in the cycle it is accepted and lands in the result
// register; its 0 to NUMBER_DIGITS+5 bytes then leave one per cycle while
// out_ready is high, through the single output port. the next item is taken
// in the cycle the last byte goes out. out_ready low holds the current byte
// and, through in_ready, the input side. reset puts the filter at a line start
// with the counter at zero, options off.
module text_line_number_and_escape_filter_top
    import tlnef_pkg::*;
#(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            in_byte,
    input  logic                  new_file,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  last
);

    tlnef_cfg_t                  cfg;
    tlnef_body_t                 body;
    logic [NUMBER_DIGITS:0][7:0] prefix;
    logic                        emit, num, busy, done, accept;

    assign in_ready = !busy || done;
    assign accept = in_valid && in_ready;

    tlnef_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    tlnef_front #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .accept   (accept),
        .in_byte  (in_byte),
        .new_file (new_file),
        .emit     (emit),
        .num      (num),
        .prefix   (prefix),
        .body     (body)
    );

    tlnef_ser #(
        .NUMBER_DIGITS (NUMBER_DIGITS)
    ) u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && emit),
        .num       (num),
        .prefix    (prefix),
        .body      (body),
        .busy      (busy),
        .done      (done),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last)
    );

    // no new item while the current one still has bytes to send
    a_hold_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> !in_ready)
        else $error("input taken in the middle of an item");

    // a non-final byte taken is always followed by another byte
    a_item_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=> out_valid)
        else $error("item cut short");

    a_stall_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no pending output");

endmodule

/* rtl/tlnef_cfg.sv */
// tlnef_cfg: option registers behind the plain write port
// depends on tlnef_pkg
module tlnef_cfg
    import tlnef_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output tlnef_cfg_t            cfg
);

    tlnef_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_NUMBER_LINES:    cfg_reg.number_lines <= wr_data[0];
                REG_NUMBER_NONBLANK: cfg_reg.number_nonblank_only <= wr_data[0];
                REG_SQUEEZE_BLANK:   cfg_reg.squeeze_blank <= wr_data[0];
                REG_SHOW_ENDS:       cfg_reg.show_ends <= wr_data[0];
                REG_SHOW_TABS:       cfg_reg.show_tabs <= wr_data[0];
                REG_SHOW_NONPRINT:   cfg_reg.show_nonprint <= wr_data[0];
                default:             ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/tlnef_front.sv */
// tlnef_front: line state, bcd line counter and per-byte rewrite decode
// depends on tlnef_pkg
module tlnef_front
    import tlnef_pkg::*;
#(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tlnef_cfg_t                        cfg,
    input  logic                              accept,
    input  logic [7:0]                        in_byte,
    input  logic                              new_file,
    output logic                              emit,
    output logic                              num,
    output logic [NUMBER_DIGITS:0][7:0]       prefix,
    output tlnef_body_t                       body
);

    localparam int CNT_W = 4 * NUMBER_DIGITS;

    logic             at_line_start_reg, at_line_start_next;
    logic             blank_seen_reg, blank_seen_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic             eff_at, eff_blank;
    logic [CNT_W-1:0] eff_count, inc_count;
    logic             is_nl, squeezed, full;

    // restart applies before the byte is handled
    assign eff_at    = new_file | at_line_start_reg;
    assign eff_blank = new_file ? 1'b0 : blank_seen_reg;
    assign eff_count = new_file ? '0 : count_reg;
    assign is_nl     = (in_byte == CH_NL);

    assign squeezed = eff_at && cfg.squeeze_blank && is_nl && eff_blank;
    assign num = eff_at && !squeezed && cfg.number_lines &&
                 (!cfg.number_nonblank_only || !is_nl);
    assign emit = !squeezed;

    // saturating bcd increment
    always_comb
    begin
        logic       carry;
        logic [3:0] d;
        carry = 1'b1;
        inc_count = eff_count;
        for (int i = 0; i < NUMBER_DIGITS; i++)
        begin
            d = eff_count[4*i +: 4];
            if (carry)
            begin
                inc_count[4*i +: 4] = (d >= 4'd9) ? 4'd0 : d + 4'd1;
            end
            carry = carry & (d == 4'd9);
        end
        full = carry;
    end

    always_comb
    begin
        at_line_start_next = at_line_start_reg;
        blank_seen_next    = blank_seen_reg;
        count_next         = count_reg;
        if (accept)
        begin
            at_line_start_next = squeezed ? 1'b1 : is_nl;
            blank_seen_next    = eff_blank;
            count_next         = eff_count;
            if (eff_at && cfg.squeeze_blank)
            begin
                blank_seen_next = is_nl;
            end
            if (num && !full)
            begin
                count_next = inc_count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_line_start_reg <= 1'b1;
            blank_seen_reg    <= 1'b0;
            count_reg         <= '0;
        end
        else
        begin
            at_line_start_reg <= at_line_start_next;
            blank_seen_reg    <= blank_seen_next;
            count_reg         <= count_next;
        end
    end

    // number text, most significant digit first, then a tab
    always_comb
    begin
        logic             lead;
        logic [3:0]       d;
        logic [CNT_W-1:0] shown;
        shown = full ? eff_count : inc_count;
        lead = 1'b1;
        for (int i = NUMBER_DIGITS - 1; i >= 0; i--)
        begin
            d = shown[4*i +: 4];
            if (d != 4'd0)
            begin
                lead = 1'b0;
            end
            prefix[NUMBER_DIGITS - 1 - i] = (lead && i != 0) ? CH_SPACE
                                            : CH_ZERO + {4'd0, d};
        end
        prefix[NUMBER_DIGITS] = CH_TAB;
    end

    // body bytes
    always_comb
    begin
        logic [7:0] low7;
        logic [7:0] e0, e1;
        logic [BODY_LEN_W-1:0] elen;
        low7 = {1'b0, in_byte[6:0]};
        e0 = low7;
        e1 = low7;
        elen = 3'd1;
        body.bytes = '0;
        body.len = 3'd1;
        if (is_nl)
        begin
            if (cfg.show_ends)
            begin
                body.bytes[0] = CH_DOLLAR;
                body.bytes[1] = CH_NL;
                body.len = 3'd2;
            end
            else
            begin
                body.bytes[0] = CH_NL;
            end
        end
        else if (in_byte == CH_TAB)
        begin
            if (cfg.show_tabs)
            begin
                body.bytes[0] = CH_CARET;
                body.bytes[1] = CH_I;
                body.len = 3'd2;
            end
            else
            begin
                body.bytes[0] = CH_TAB;
            end
        end
        else if (cfg.show_nonprint)
        begin
            if (low7 == CH_DEL)
            begin
                e0 = CH_CARET;
                e1 = CH_QMARK;
                elen = 3'd2;
            end
            else if (low7 < CH_CTRL_END)
            begin
                e0 = CH_CARET;
                e1 = low7 + CTRL_OFFSET;
                elen = 3'd2;
            end
            if (in_byte[7])
            begin
                body.bytes[0] = CH_M;
                body.bytes[1] = CH_DASH;
                body.bytes[2] = e0;
                body.bytes[3] = e1;
                body.len = elen + 3'd2;
            end
            else
            begin
                body.bytes[0] = e0;
                body.bytes[1] = e1;
                body.len = elen;
            end
        end
        else
        begin
            body.bytes[0] = in_byte;
        end
    end

endmodule

/* rtl/tlnef_ser.sv */
// tlnef_ser: result register holding one rewritten item and its byte sequencer
// depends on tlnef_pkg
module tlnef_ser
    import tlnef_pkg::*;
#(
    parameter int NUMBER_DIGITS = 6
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic                        num,
    input  logic [NUMBER_DIGITS:0][7:0] prefix,
    input  tlnef_body_t                 body,
    output logic                        busy,
    output logic                        done,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  out_byte,
    output logic                        last
);

    localparam int PRE_LEN = NUMBER_DIGITS + 1;
    localparam int MAX_RES = PRE_LEN + BODY_MAX;
    localparam int IDX_W = $clog2(MAX_RES);
    localparam int PRE_W = $clog2(PRE_LEN);
    localparam logic [IDX_W-1:0] PRE_LEN_I = IDX_W'(PRE_LEN);

    logic                        valid_reg, valid_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [IDX_W-1:0]            total_m1_reg;
    logic                        num_reg;
    logic [NUMBER_DIGITS:0][7:0] prefix_reg;
    tlnef_body_t                 body_reg;

    logic       fire;
    logic [IDX_W-1:0] body_off;

    assign last = (idx_reg == total_m1_reg);
    assign fire = valid_reg && out_ready;
    assign done = fire && last;
    assign busy = valid_reg;
    assign out_valid = valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next = idx_reg;
        if (fire)
        begin
            if (last)
            begin
                idx_next = '0;
                valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            num_reg      <= num;
            prefix_reg   <= prefix;
            body_reg     <= body;
            total_m1_reg <= (num ? PRE_LEN_I : '0) + IDX_W'(body.len) - 1'b1;
        end
    end

    assign body_off = num_reg ? idx_reg - PRE_LEN_I : idx_reg;

    always_comb
    begin
        if (num_reg && idx_reg < PRE_LEN_I)
        begin
            out_byte = prefix_reg[idx_reg[PRE_W-1:0]];
        end
        else
        begin
            out_byte = body_reg.bytes[body_off[1:0]];
        end
    end

endmodule
